### rtl/pal_pkg.sv
// Shared types and codes for the positional array list.
package pal_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_DISPLAY   = 3'd7
  } opcode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    CM_HOLD       = 2'd0,
    CM_FROM_LEFT  = 2'd1,
    CM_FROM_RIGHT = 2'd2,
    CM_LOAD       = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    word_t      data;
  } cell_ctl_t;

endpackage

### rtl/pal_cell.sv
// One storage cell of the list chain, fed by either neighbour or by a load word.
module pal_cell (
  input  logic              clk,
  input  pal_pkg::cell_ctl_t ctl,
  input  pal_pkg::word_t    left,
  input  pal_pkg::word_t    right,
  output pal_pkg::word_t    q
);
  import pal_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_FROM_LEFT:  q <= left;
      CM_FROM_RIGHT: q <= right;
      CM_LOAD:       q <= ctl.data;
      default:       q <= q;
    endcase
  end

endmodule

### rtl/positional_array_list_top.sv
// Top level of the positional array list: command decode, cell chain and result register.
// Inserts, deletes and errors register their one result from the exec state once the result register
// is free, and the next command is taken back in idle. Search and display rotate the chain once
// through cell 0 in DEPTH steps; a search answers from the fin state after the rotation, and a
// display emits one item per step that holds an entry (a step waits while the result side stalls).
// rst clears the fill count, sequencer, step counter, search match and result valid only.
module positional_array_list_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] value,
  input  logic [4:0]         position,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         status,
  output logic signed [31:0] word,
  output logic [4:0]         where,
  output logic [4:0]         length,
  output logic               last
);
  import pal_pkg::*;

  // Index, fill and working widths. The working width holds any position, fill + 1 and
  // the step counter without wrapping.
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = ((FW > 5) ? FW : 5) + 1;

  // The sequencer: idle waits for a command, exec issues the single-result commands,
  // scan rotates the chain for search and display, fin issues the search result.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t          state;
  opcode_t         cmd_op;
  word_t           cmd_key;
  logic [4:0]      cmd_pos;
  logic [FW-1:0]   fill;
  logic [IW-1:0]   cnt;
  logic [CW-1:0]   found;

  word_t           cells [DEPTH];
  cell_ctl_t       ctls  [DEPTH];

  logic [CW-1:0]   fill_c;
  logic [CW-1:0]   pos_c;
  logic [CW-1:0]   cnt_c;
  logic [CW-1:0]   idx_c;
  logic            out_free;
  logic            res_load;
  logic            is_ins;
  logic            is_del;
  logic            full;
  logic            ins_bad;
  logic            del_bad;
  logic            do_ins;
  logic            do_del;
  logic            scan_emit;
  logic            scan_step;
  logic            scan_end;

  // The command side is held off whenever a command is still being worked on.
  assign cmd_stall = (state != S_IDLE);

  // The result register may be written when it is empty or is being taken this cycle.
  assign out_free = !res_valid || !res_stall;

  assign fill_c = CW'(fill);
  assign pos_c  = CW'(cmd_pos);
  assign cnt_c  = CW'(cnt);

  assign is_ins = (cmd_op inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_POS});
  assign is_del = (cmd_op inside {OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS});
  assign full   = (fill_c >= CW'(DEPTH));

  // A positional insert may go anywhere from the front to just past the back; a positional
  // delete must name an existing entry.
  assign ins_bad = (cmd_op == OP_INS_POS) &&
                   ((pos_c == '0) || (pos_c > fill_c + CW'(1)));
  assign del_bad = (cmd_op == OP_DEL_POS) && ((pos_c == '0) || (pos_c > fill_c));

  // Zero-based index of the entry that the command works on.
  always_comb begin
    case (cmd_op)
      OP_INS_FRONT, OP_DEL_FRONT: idx_c = '0;
      OP_INS_BACK:                idx_c = fill_c;
      OP_DEL_BACK:                idx_c = fill_c - CW'(1);
      default:                    idx_c = pos_c - CW'(1);
    endcase
  end

  assign do_ins = (state == S_EXEC) && out_free && is_ins && !full && !ins_bad;
  assign do_del = (state == S_EXEC) && out_free && is_del && (fill != '0) && !del_bad;

  // During a scan the chain rotates by one each step so that entry cnt sits in cell 0.
  // A display step that has an entry to show waits for room in the result register.
  assign scan_emit = (cmd_op == OP_DISPLAY) && (cnt_c < fill_c);
  assign scan_step = (state == S_SCAN) && (!scan_emit || out_free);
  assign scan_end  = (cnt == IW'(DEPTH - 1));

  // A new result is written into the result register at this edge.
  assign res_load = ((state == S_EXEC) && out_free && (is_ins || is_del || (fill == '0))) ||
                    (scan_step && scan_emit) || ((state == S_FIN) && out_free);

  // Per-cell control: an insert moves the entries at and above the index up by one and
  // loads the new word at the index; a delete pulls the entries above the index down;
  // a scan step rotates the whole chain towards cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctls[i].data = cmd_key;
      if (do_ins && (CW'(i) > idx_c)) begin
        ctls[i].mode = CM_FROM_LEFT;
      end else if (do_ins && (CW'(i) == idx_c)) begin
        ctls[i].mode = CM_LOAD;
      end else if (do_del && (CW'(i) >= idx_c)) begin
        ctls[i].mode = CM_FROM_RIGHT;
      end else if (scan_step) begin
        ctls[i].mode = CM_FROM_RIGHT;
      end else begin
        ctls[i].mode = CM_HOLD;
      end
    end

    pal_cell u_cell (
      .clk   (clk),
      .ctl   (ctls[i]),
      .left  (cells[(i + DEPTH - 1) % DEPTH]),
      .right (cells[(i + 1) % DEPTH]),
      .q     (cells[i])
    );
  end

  // Sequencer, fill count, search tracking and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
      cnt       <= '0;
      found     <= '0;
    end else begin
      // A taken result empties the register unless a new one is written at the same edge.
      if (res_valid && !res_stall && !res_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_op  <= opcode_t'(opcode);
            cmd_key <= word_t'(value);
            cmd_pos <= position;
            state   <= S_EXEC;
          end
        end

        S_EXEC: begin
          cnt   <= '0;
          found <= '0;
          if (!is_ins && !is_del && (fill != '0)) begin
            // Search or display on a non-empty list runs a full rotation.
            state <= S_SCAN;
          end else if (out_free) begin
            res_valid <= 1'b1;
            where     <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
            if (do_ins) begin
              status <= ST_OK;
              word   <= '0;
              fill   <= fill + FW'(1);
              length <= 5'(fill_c + CW'(1));
            end else if (do_del) begin
              status <= ST_OK;
              word   <= cells[idx_c[IW-1:0]];
              fill   <= fill - FW'(1);
              length <= 5'(fill_c - CW'(1));
            end else begin
              // A full list wins over a bad position; an empty list is reported only when
              // the command is not an insert.
              word   <= '0;
              length <= 5'(fill_c);
              if (is_ins && full) begin
                status <= ST_FULL;
              end else if (is_ins || (fill != '0)) begin
                status <= ST_BAD_POS;
              end else begin
                status <= ST_EMPTY;
              end
            end
          end
        end

        S_SCAN: begin
          if (scan_step) begin
            cnt <= cnt + IW'(1);
            if (scan_emit) begin
              res_valid <= 1'b1;
              status    <= ST_OK;
              word      <= cells[0];
              where     <= 5'(cnt_c + CW'(1));
              length    <= 5'(fill_c);
              last      <= (cnt_c + CW'(1) == fill_c);
            end
            if ((cmd_op == OP_SEARCH) && (cnt_c < fill_c) && (cells[0] == cmd_key)) begin
              found <= cnt_c + CW'(1);
            end
            if (scan_end) begin
              state <= (cmd_op == OP_SEARCH) ? S_FIN : S_IDLE;
            end
          end
        end

        S_FIN: begin
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= (found == '0) ? ST_NOT_FOUND : ST_OK;
            word      <= '0;
            where     <= 5'(found);
            length    <= 5'(fill_c);
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
